// ----- rtl/itt_pkg.sv -----
// Shared types and constants for the interval timer table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package itt_pkg;

  localparam int SLOTS    = 10;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W   = 6;
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 16;
  localparam int TICK_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic step;
    logic wr_slot;
    logic mark_ok;
    logic load_fire;
    logic load_final;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            at_end;
    logic            out_free;
  } sts_t;

endpackage

// ----- rtl/itt_ifs.sv -----
// Valid/ready channel interfaces for the interval timer table.
// Depends on itt_pkg for the field widths.
interface itt_in_if;
  logic                          valid;
  logic                          ready;
  logic [itt_pkg::OP_W-1:0]      op;
  logic [itt_pkg::HANDLE_W-1:0]  handle;
  logic [itt_pkg::TICK_W-1:0]    interval;
  logic                          one_shot;
  logic [itt_pkg::TICK_W-1:0]    now_tick;

  modport source (output valid, op, handle, interval, one_shot, now_tick, input ready);
  modport sink   (input valid, op, handle, interval, one_shot, now_tick, output ready);
endinterface

interface itt_out_if;
  logic                          valid;
  logic                          ready;
  logic [itt_pkg::KIND_W-1:0]    kind;
  logic [itt_pkg::STAT_W-1:0]    status;
  logic [itt_pkg::HANDLE_W-1:0]  fired_handle;
  logic [itt_pkg::SLOT_W-1:0]    fired_slot;
  logic                          last;

  modport source (output valid, kind, status, fired_handle, fired_slot, last, input ready);
  modport sink   (input valid, kind, status, fired_handle, fired_slot, last, output ready);
endinterface

// ----- rtl/itt_ctrl.sv -----
// Controller state machine for the interval timer table.
// Depends on itt_pkg for the state, command and status types.
module itt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  itt_pkg::sts_t   sts,
  output itt_pkg::cmd_t   cmd
);

  itt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = itt_pkg::S_SCAN;
        end
      end
      itt_pkg::S_SCAN: begin
        case (sts.op)
          itt_pkg::OP_SET, itt_pkg::OP_CLEAR: begin
            if (sts.hit || sts.at_end) begin
              state_nxt = itt_pkg::S_REPLY;
            end
          end
          itt_pkg::OP_POLL: begin
            if (sts.at_end && (!sts.hit || sts.out_free)) begin
              state_nxt = itt_pkg::S_REPLY;
            end
          end
          default: begin
            state_nxt = itt_pkg::S_REPLY;
          end
        endcase
      end
      itt_pkg::S_REPLY: begin
        if (sts.out_free) begin
          state_nxt = itt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = itt_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      itt_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      itt_pkg::S_SCAN: begin
        case (sts.op)
          itt_pkg::OP_SET, itt_pkg::OP_CLEAR: begin
            if (sts.hit) begin
              cmd.wr_slot = 1'b1;
              cmd.mark_ok = 1'b1;
            end else if (!sts.at_end) begin
              cmd.step = 1'b1;
            end
          end
          itt_pkg::OP_POLL: begin
            if (sts.hit) begin
              if (sts.out_free) begin
                cmd.wr_slot   = 1'b1;
                cmd.load_fire = 1'b1;
                cmd.step      = !sts.at_end;
              end
            end else begin
              cmd.step = !sts.at_end;
            end
          end
          default: begin
          end
        endcase
      end
      itt_pkg::S_REPLY: begin
        cmd.load_final = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/itt_dp.sv -----
// Datapath of the interval timer table: slot storage, scan index and result register.
// Depends on itt_pkg for widths, codes and the command and status types.
module itt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itt_pkg::cmd_t                 cmd,
  output itt_pkg::sts_t                 sts,
  input  logic [itt_pkg::OP_W-1:0]      in_op,
  input  logic [itt_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [itt_pkg::TICK_W-1:0]    in_interval,
  input  logic                          in_one_shot,
  input  logic [itt_pkg::TICK_W-1:0]    in_now_tick,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [itt_pkg::KIND_W-1:0]    out_kind,
  output logic [itt_pkg::STAT_W-1:0]    out_status,
  output logic [itt_pkg::HANDLE_W-1:0]  out_fired_handle,
  output logic [itt_pkg::SLOT_W-1:0]    out_fired_slot,
  output logic                          out_last
);

  logic [itt_pkg::HANDLE_W-1:0] handle_r   [itt_pkg::SLOTS];
  logic [itt_pkg::TICK_W-1:0]   interval_r [itt_pkg::SLOTS];
  logic                         once_r     [itt_pkg::SLOTS];
  logic [itt_pkg::TICK_W-1:0]   last_r     [itt_pkg::SLOTS];

  // Latched item.
  logic [itt_pkg::OP_W-1:0]     op_r;
  logic [itt_pkg::HANDLE_W-1:0] hdl_r;
  logic [itt_pkg::TICK_W-1:0]   ival_r;
  logic                         one_shot_r;
  logic [itt_pkg::TICK_W-1:0]   now_r;
  logic [itt_pkg::STAT_W-1:0]   status_r;
  logic [itt_pkg::IDX_W-1:0]    idx_r;

  // Result register.
  logic                         out_valid_r;
  logic [itt_pkg::KIND_W-1:0]   out_kind_r;
  logic [itt_pkg::STAT_W-1:0]   out_status_r;
  logic [itt_pkg::HANDLE_W-1:0] out_handle_r;
  logic [itt_pkg::SLOT_W-1:0]   out_slot_r;
  logic                         out_last_r;

  logic [itt_pkg::HANDLE_W-1:0] cur_handle;
  logic [itt_pkg::TICK_W-1:0]   elapsed;
  logic                         hit;

  assign cur_handle = handle_r[idx_r];
  assign elapsed    = now_r - last_r[idx_r];

  always_comb begin
    case (op_r)
      itt_pkg::OP_SET:   hit = (cur_handle == '0);
      itt_pkg::OP_CLEAR: hit = (cur_handle == hdl_r);
      itt_pkg::OP_POLL:  hit = (cur_handle != '0) && (elapsed >= interval_r[idx_r]);
      default:           hit = 1'b0;
    endcase
  end

  assign sts.op       = op_r;
  assign sts.hit      = hit;
  assign sts.at_end   = (idx_r == itt_pkg::IDX_W'(itt_pkg::SLOTS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_op;
      hdl_r      <= in_handle;
      ival_r     <= in_interval;
      one_shot_r <= in_one_shot;
      now_r      <= in_now_tick;
      idx_r      <= '0;
      case (in_op)
        itt_pkg::OP_SET:   status_r <= itt_pkg::ST_FULL;
        itt_pkg::OP_CLEAR: status_r <= itt_pkg::ST_MISSING;
        default:           status_r <= itt_pkg::ST_OK;
      endcase
    end else begin
      if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.mark_ok) begin
        status_r <= itt_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < itt_pkg::SLOTS; i++) begin
        handle_r[i]   <= '0;
        interval_r[i] <= '0;
        once_r[i]     <= 1'b0;
        last_r[i]     <= '0;
      end
    end else if (cmd.wr_slot) begin
      case (op_r)
        itt_pkg::OP_SET: begin
          handle_r[idx_r]   <= hdl_r;
          interval_r[idx_r] <= ival_r;
          once_r[idx_r]     <= one_shot_r;
        end
        itt_pkg::OP_CLEAR: begin
          handle_r[idx_r]   <= '0;
          interval_r[idx_r] <= '0;
        end
        itt_pkg::OP_POLL: begin
          last_r[idx_r] <= now_r;
          if (once_r[idx_r]) begin
            handle_r[idx_r]   <= '0;
            interval_r[idx_r] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_fire || cmd.load_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fire) begin
      out_kind_r   <= itt_pkg::KIND_FIRED;
      out_status_r <= itt_pkg::ST_OK;
      out_handle_r <= cur_handle;
      out_slot_r   <= itt_pkg::SLOT_W'(idx_r);
      out_last_r   <= 1'b0;
    end else if (cmd.load_final) begin
      out_kind_r   <= (op_r == itt_pkg::OP_POLL) ? itt_pkg::KIND_END : itt_pkg::KIND_STATUS;
      out_status_r <= status_r;
      out_handle_r <= '0;
      out_slot_r   <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_fired_handle = out_handle_r;
  assign out_fired_slot   = out_slot_r;
  assign out_last         = out_last_r;

endmodule

// ----- rtl/interval_timer_table_top.sv -----
// Top level of the interval timer table: controller, datapath and the two channels.
// Depends on itt_pkg, itt_in_if, itt_out_if, itt_ctrl and itt_dp.
//
// The block keeps SLOTS interval timers and works on one request at a time. An
// item is taken in the idle state, then the controller walks the slots in order,
// one slot per cycle unless a fire result waits for the output register, and
// finishes in the reply state, which loads the closing result once the output
// register is free. A set request stops at the first free slot and a clear
// request at the first slot that holds its handle; a poll always visits every
// slot. A fire result is loaded in the same cycle that the walk passes its
// slot; when the output register still holds a result that has not been taken,
// the walk waits on that slot until the transfer happens. The output register
// sits between the walk and the result channel, so the closing result of one
// request may still wait for its transfer while the next request is taken.
// Each poll uses the tick it carried for all of its slots, and every request
// gives a run of results whose final one has last set.
module interval_timer_table_top (
  input logic   clk,
  input logic   rst_n,
  itt_in_if.sink    in_ch,
  itt_out_if.source out_ch
);

  itt_pkg::cmd_t cmd;
  itt_pkg::sts_t sts;
  logic          in_ready;

  // The controller owns the handshake on the input side.
  itt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // The datapath holds the slot table and the output register.
  itt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_handle        (in_ch.handle),
    .in_interval      (in_ch.interval),
    .in_one_shot      (in_ch.one_shot),
    .in_now_tick      (in_ch.now_tick),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_kind         (out_ch.kind),
    .out_status       (out_ch.status),
    .out_fired_handle (out_ch.fired_handle),
    .out_fired_slot   (out_ch.fired_slot),
    .out_last         (out_ch.last)
  );

  // A result is only loaded when the output register is empty or being emptied.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_fire || cmd.load_final) |-> sts.out_free)
    else $error("result loaded over a pending result");

  // A fire result and a closing result never compete for the output register.
  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_fire && cmd.load_final))
    else $error("fire and closing result loaded together");

  // A closing result appears with last set on the next cycle.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_final |=> (out_ch.valid && out_ch.last))
    else $error("closing result without last");

  // A fire result names a used timer and is never the last result.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_fire |=> (out_ch.valid && !out_ch.last &&
                       out_ch.kind == itt_pkg::KIND_FIRED && out_ch.fired_handle != '0))
    else $error("malformed fire result");

endmodule
